// ===== src/uvld_pkg.sv =====
`timescale 1ns / 1ps
package uvld_pkg;

  localparam int unsigned LimitMaxDefault = 65535;
  localparam int unsigned CountW          = 17;
  localparam int unsigned MaxBytesW       = 16;
  localparam int unsigned CfgIdxW         = 1;
  localparam int unsigned CfgDataW        = 16;
  localparam logic [MaxBytesW-1:0] MaxBytesReset = 16'd255;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_BYTES   = 1'b0,
    REG_ALLOW_EMPTY = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LONG  = 2'd1,
    STATUS_INVALID   = 2'd2,
    STATUS_BAD_UTF8  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RULE_NONE   = 3'd0,
    RULE_E0_MIN = 3'd1,
    RULE_ED_MAX = 3'd2,
    RULE_F0_MIN = 3'd3,
    RULE_F4_MAX = 3'd4
  } rule_t;

  typedef struct packed {
    logic [CountW-1:0] byte_count;
    logic [1:0]        cont_left;
    rule_t             rule;
    logic              enc_bad;
    logic              rsv_seen;
  } field_state_t;

  localparam field_state_t FieldClear = '{
    byte_count: '0,
    cont_left:  2'd0,
    rule:       RULE_NONE,
    enc_bad:    1'b0,
    rsv_seen:   1'b0
  };

  typedef struct packed {
    logic [MaxBytesW-1:0] limit;
    logic                 allow_empty;
  } cfg_t;

endpackage

// ===== src/uvld_byte_check.sv =====
`timescale 1ns / 1ps
module uvld_byte_check #(
  parameter int unsigned LIMIT_MAX = uvld_pkg::LimitMaxDefault
) (
  input  uvld_pkg::field_state_t st,
  input  uvld_pkg::cfg_t         cfg,
  input  logic [7:0]             data_byte,
  input  logic                   byte_present,
  input  logic                   last,
  output uvld_pkg::field_state_t st_nxt,
  output uvld_pkg::status_t      status
);
  import uvld_pkg::*;

  localparam logic [CountW-1:0] CountSat = CountW'(LIMIT_MAX + 1);

  field_state_t upd;
  logic         cont_ok;
  logic         enc_bad_end;

  always_comb begin
    upd = st;
    cont_ok = 1'b0;
    if (byte_present) begin
      if (st.byte_count < CountSat) begin
        upd.byte_count = st.byte_count + CountW'(1);
      end
      if (data_byte == 8'h00 || data_byte == 8'h0D || data_byte == 8'h0A ||
          data_byte == 8'h7C) begin
        upd.rsv_seen = 1'b1;
      end
      upd.rule = RULE_NONE;
      if (st.cont_left != 2'd0) begin
        cont_ok = (data_byte & 8'hC0) == 8'h80;
        case (st.rule)
          RULE_E0_MIN: cont_ok = cont_ok && (data_byte >= 8'hA0);
          RULE_ED_MAX: cont_ok = cont_ok && (data_byte < 8'hA0);
          RULE_F0_MIN: cont_ok = cont_ok && (data_byte >= 8'h90);
          RULE_F4_MAX: cont_ok = cont_ok && (data_byte < 8'h90);
          default:     cont_ok = cont_ok;
        endcase
        if (cont_ok) begin
          upd.cont_left = st.cont_left - 2'd1;
        end else begin
          upd.enc_bad   = 1'b1;
          upd.cont_left = 2'd0;
        end
      end else if ((data_byte & 8'h80) == 8'h00) begin
        upd.cont_left = 2'd0;
      end else if ((data_byte & 8'hE0) == 8'hC0) begin
        if (data_byte < 8'hC2) begin
          upd.enc_bad = 1'b1;
        end else begin
          upd.cont_left = 2'd1;
        end
      end else if ((data_byte & 8'hF0) == 8'hE0) begin
        upd.cont_left = 2'd2;
        if (data_byte == 8'hE0) begin
          upd.rule = RULE_E0_MIN;
        end else if (data_byte == 8'hED) begin
          upd.rule = RULE_ED_MAX;
        end
      end else if ((data_byte & 8'hF8) == 8'hF0) begin
        if (data_byte > 8'hF4) begin
          upd.enc_bad = 1'b1;
        end else begin
          upd.cont_left = 2'd3;
          if (data_byte == 8'hF0) begin
            upd.rule = RULE_F0_MIN;
          end else if (data_byte == 8'hF4) begin
            upd.rule = RULE_F4_MAX;
          end
        end
      end else begin
        upd.enc_bad = 1'b1;
      end
    end
  end

  assign enc_bad_end = upd.enc_bad || (upd.cont_left != 2'd0);

  always_comb begin
    if (upd.byte_count > {1'b0, cfg.limit}) begin
      status = STATUS_TOO_LONG;
    end else if (upd.byte_count == '0 && !cfg.allow_empty) begin
      status = STATUS_INVALID;
    end else if (enc_bad_end) begin
      status = STATUS_BAD_UTF8;
    end else if (upd.rsv_seen) begin
      status = STATUS_INVALID;
    end else begin
      status = STATUS_OK;
    end
  end

  assign st_nxt = last ? FieldClear : upd;

endmodule

// ===== src/utf8_text_field_validator_core.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake                  Payload
// in       input      in_valid / in_ready        in_data_byte, in_byte_present, in_last
// out      output     out_valid / out_ready      out_status, out_field_length
// cfg      input      cfg_we                     cfg_index, cfg_wdata
//
// One word is taken per cycle while in_ready is high: it is registered, checked
// against the field state from the stage-1 register and, if it ends the field,
// its status word is registered at the output once stage 1 lets the word go.
// Synchronous active-low reset clears the field state and restores the register
// defaults. A stalled output holds up a last word and those after it; others go on.
module utf8_text_field_validator_core #(
  parameter int unsigned LIMIT_MAX = uvld_pkg::LimitMaxDefault
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_byte_present,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [uvld_pkg::CountW-1:0]     out_field_length,
  input  logic                            cfg_we,
  input  logic [uvld_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [uvld_pkg::CfgDataW-1:0]   cfg_wdata
);
  import uvld_pkg::*;

  localparam logic [MaxBytesW-1:0] LimitCap = MaxBytesW'(LIMIT_MAX);

  logic [MaxBytesW-1:0] max_bytes_r;
  logic                 allow_empty_r;
  cfg_t                 cfg;

  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic                 s1_present_r;
  logic                 s1_last_r;
  logic                 s1_go;

  field_state_t         st_r;
  field_state_t         st_nxt;
  status_t              status;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [CountW-1:0]    out_len_r;
  logic                 out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r   <= MaxBytesReset;
      allow_empty_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_BYTES:   max_bytes_r   <= cfg_wdata[MaxBytesW-1:0];
        REG_ALLOW_EMPTY: allow_empty_r <= cfg_wdata[0];
        default:         max_bytes_r   <= max_bytes_r;
      endcase
    end
  end

  assign cfg.limit       = (max_bytes_r < LimitCap) ? max_bytes_r : LimitCap;
  assign cfg.allow_empty = allow_empty_r;

  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r    <= in_data_byte;
      s1_present_r <= in_byte_present;
      s1_last_r    <= in_last;
    end
  end

  uvld_byte_check #(
    .LIMIT_MAX (LIMIT_MAX)
  ) u_check (
    .st           (st_r),
    .cfg          (cfg),
    .data_byte    (s1_byte_r),
    .byte_present (s1_present_r),
    .last         (s1_last_r),
    .st_nxt       (st_nxt),
    .status       (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FieldClear;
    end else if (s1_go) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The count reported is the one after this word, taken before the clear.
  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_status_r <= status;
      out_len_r    <= (s1_present_r && st_r.byte_count < CountW'(LIMIT_MAX + 1))
                      ? st_r.byte_count + CountW'(1) : st_r.byte_count;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_field_length = out_len_r;

endmodule
